// ----- hw/rtl/kmor_pkg.sv -----
// Shared types and constants for the k-way merge of occurrence records.
`default_nettype none
package kmor_pkg;

	// Number of run heads held by the block.
	localparam int MAX_RUNS = 16;
	// Runs addressable by the 4-bit run index.
	localparam int INDEX_SPAN = 16;
	localparam int RUN_LIMIT = (MAX_RUNS < INDEX_SPAN) ? MAX_RUNS : INDEX_SPAN;
	localparam int RUN_W = $clog2(MAX_RUNS);
	localparam int CFG_W = 5;
	localparam int IDX_IN_W = 4;

	localparam logic [CFG_W-1:0] RUNS_MAX = CFG_W'(RUN_LIMIT);
	localparam logic [CFG_W-1:0] RUNS_MIN = CFG_W'(1);

	// One run head; field order gives the sort order as a packed vector.
	typedef struct packed {
		logic [63:0] hash;
		logic [31:0] page;
		logic [31:0] pos;
	} head_t;

	// Control from the sequencer to the minimum unit.
	typedef struct packed {
		logic             start;
		logic             en;
		logic             vld;
		logic [RUN_W-1:0] idx;
	} cmp_ctl_t;

	// Current best head found by the minimum unit.
	typedef struct packed {
		logic             found;
		logic [RUN_W-1:0] idx;
	} cmp_best_t;

	// Clamp the register value to the number of runs taking part.
	function automatic logic [CFG_W-1:0] active_runs(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] n;
		n = v;
		if (n < RUNS_MIN) n = RUNS_MIN;
		if (n > RUNS_MAX) n = RUNS_MAX;
		return n;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/kmor_head_ram.sv -----
// Synchronous head memory: one write port, one registered read port.
`default_nettype none
module kmor_head_ram (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [kmor_pkg::RUN_W-1:0] waddr,
	input  wire kmor_pkg::head_t          wdata,
	input  wire logic [kmor_pkg::RUN_W-1:0] raddr,
	output kmor_pkg::head_t               rdata
);
	import kmor_pkg::*;

	head_t mem [MAX_RUNS];

	// Write and read in one clocked block; read data is registered and appears in the following cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/kmor_min_unit.sv -----
// Sequenced comparator that keeps the smallest valid head seen during a scan.
`default_nettype none
module kmor_min_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire kmor_pkg::cmp_ctl_t ctl,
	input  wire kmor_pkg::head_t    rd_head,
	output kmor_pkg::cmp_best_t     best,
	output kmor_pkg::head_t         best_head
);
	import kmor_pkg::*;

	cmp_best_t best_q;
	head_t     best_head_q;
	logic      take;

	// Strictly smaller wins, so the lowest run index keeps ties.
	assign take = ctl.en && ctl.vld && (!best_q.found || (rd_head < best_head_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctl.start) begin
			best_q <= '0;
		end else if (take) begin
			best_q.found <= 1'b1;
			best_q.idx   <= ctl.idx;
		end
	end

	// Key register needs no reset; it is read only once found is set.
	always_ff @(posedge clk) begin
		if (take) begin
			best_head_q <= rd_head;
		end
	end

	assign best      = best_q;
	assign best_head = best_head_q;

endmodule
`default_nettype wire

// ----- hw/rtl/kway_merge_occurrence_records.sv -----
// Top level of the k-way merge: handshakes, run bookkeeping and scan sequencer.
// A refill that leaves some run still awaiting a refill returns to idle from the check state
// with no word. A refill that completes the set runs through the check, scan, last and emit states
// to a registered output word; the scan feeds the comparator one head memory read per run in use.
// One item is in work at a time; the next is accepted once the result sits in the output register.
// Reset clears control, valid bits and pending refills (all runs await one); heads are not cleared.
`default_nettype none
module kway_merge_occurrence_records (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [kmor_pkg::IDX_IN_W-1:0] run_index,
	input  wire logic                          has_record,
	input  wire logic [63:0]                   rec_hash,
	input  wire logic [31:0]                   page_id,
	input  wire logic [31:0]                   position,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [63:0]                        out_hash,
	output logic [31:0]                        out_page,
	output logic [31:0]                        out_position,
	output logic [kmor_pkg::IDX_IN_W-1:0]      source_run,
	output logic                               all_done,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [kmor_pkg::CFG_W-1:0]    runs_in_use
);
	import kmor_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_LAST  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]          state_q;
	logic [CFG_W-1:0]    runs_q;
	logic [CFG_W-1:0]    n_act;
	logic [CFG_W-1:0]    n_cfg;
	logic [MAX_RUNS-1:0] valid_q;
	logic [MAX_RUNS-1:0] await_q;
	logic [RUN_W-1:0]    idx_q;
	logic                cmp_en_s1;
	logic                cmp_vld_s1;
	logic [RUN_W-1:0]    cmp_idx_s1;
	logic                in_fire;
	logic                cfg_fire;
	logic                out_free;
	logic [RUN_W-1:0]    wr_run;
	logic                hit;
	logic                last_issue;
	head_t               wr_head;
	head_t               rd_head;
	head_t               best_head;
	cmp_ctl_t            ctl;
	cmp_best_t           best;

	logic                out_valid_q;
	logic [63:0]         out_hash_q;
	logic [31:0]         out_page_q;
	logic [31:0]         out_pos_q;
	logic [IDX_IN_W-1:0] out_src_q;
	logic                out_done_q;

	// Handshakes; a configuration write wins over an input word in the same cycle.
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign in_stall  = (state_q != ST_IDLE) || cfg_valid;
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign n_act = active_runs(runs_q);
	assign n_cfg = active_runs(runs_in_use);

	// A refill counts only for a run in use that awaits one.
	assign wr_run  = RUN_W'(run_index);
	assign hit     = ({1'b0, run_index} < n_act) && await_q[wr_run];
	assign wr_head = '{hash: rec_hash, page: page_id, pos: position};

	assign last_issue = (CFG_W'(idx_q) == (n_act - CFG_W'(1)));

	kmor_head_ram u_ram (
		.clk   (clk),
		.we    (in_fire && hit && has_record),
		.waddr (wr_run),
		.wdata (wr_head),
		.raddr (idx_q),
		.rdata (rd_head)
	);

	assign ctl = '{start: (state_q == ST_CHECK), en: cmp_en_s1, vld: cmp_vld_s1,
	               idx: cmp_idx_s1};

	kmor_min_unit u_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_head   (rd_head),
		.best      (best),
		.best_head (best_head)
	);

	// Sequencer, run bookkeeping and read stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			runs_q     <= RUNS_MAX;
			valid_q    <= '0;
			await_q    <= '1;
			idx_q      <= '0;
			cmp_en_s1  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_en_s1  <= (state_q == ST_SCAN);
			cmp_vld_s1 <= valid_q[idx_q];
			cmp_idx_s1 <= idx_q;
			case (state_q)
				ST_IDLE: begin
					if (cfg_fire) begin
						runs_q  <= runs_in_use;
						valid_q <= '0;
						for (int i = 0; i < MAX_RUNS; i++) begin
							await_q[i] <= (i < int'(n_cfg));
						end
					end else if (in_fire) begin
						if (hit) begin
							await_q[wr_run] <= 1'b0;
							valid_q[wr_run] <= has_record;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					idx_q   <= '0;
					state_q <= (|await_q) ? ST_IDLE : ST_SCAN;
				end
				ST_SCAN: begin
					if (last_issue) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + RUN_W'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						if (best.found) begin
							valid_q[best.idx] <= 1'b0;
							await_q[best.idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: the smallest head, or a done word with zero fields.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			if (best.found) begin
				out_hash_q <= best_head.hash;
				out_page_q <= best_head.page;
				out_pos_q  <= best_head.pos;
				out_src_q  <= IDX_IN_W'(best.idx);
				out_done_q <= 1'b0;
			end else begin
				out_hash_q <= '0;
				out_page_q <= '0;
				out_pos_q  <= '0;
				out_src_q  <= '0;
				out_done_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_hash     = out_hash_q;
	assign out_page     = out_page_q;
	assign out_position = out_pos_q;
	assign source_run   = out_src_q;
	assign all_done     = out_done_q;

	// A run never holds a valid head while it awaits a refill.
	a_valid_await_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & await_q) == '0)
		else $error("run both valid and awaiting refill");

	// A scan starts only when no run awaits a refill.
	a_scan_no_await: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (await_q == '0))
		else $error("scan started with a refill pending");

	// An emitted record leaves its run awaiting a refill.
	a_emit_requests: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && best.found) |=> await_q[$past(best.idx)])
		else $error("emitted run not marked for refill");

	// A done word carries no run.
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> (out_src_q == '0 && out_hash_q == '0))
		else $error("done word with nonzero fields");

endmodule
`default_nettype wire

// ----- bench/kway_merge_occurrence_records_test.sv -----
// Self-checking testbench for the k-way merge of occurrence records.
module kway_merge_occurrence_records_test;
	import kmor_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int REFILL_TARGET = 2000;
	localparam int SETTLE_CYCLES = MAX_RUNS + 8;
	localparam logic [CFG_W-1:0] RUNS_AT_RESET = CFG_W'(16);

	// One output word as the merge emits it.
	typedef struct packed {
		logic [63:0]         hash;
		logic [31:0]         page;
		logic [31:0]         pos;
		logic [IDX_IN_W-1:0] src;
		logic                done;
	} merge_word_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [IDX_IN_W-1:0] run_index;
	logic has_record;
	logic [63:0] rec_hash;
	logic [31:0] page_id;
	logic [31:0] position;
	logic out_valid;
	logic out_stall;
	logic [63:0] out_hash;
	logic [31:0] out_page;
	logic [31:0] out_position;
	logic [IDX_IN_W-1:0] source_run;
	logic all_done;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_runs;

	// Mirror of the merge state, updated as words are accepted.
	head_t heads [MAX_RUNS];
	bit head_valid [MAX_RUNS];
	bit awaiting [MAX_RUNS];
	logic [CFG_W-1:0] cfg_mirror;
	merge_word_t pending_words [$];

	// Stimulus shaping and run statistics.
	int records_left [MAX_RUNS];
	bit narrow_keys;
	bit steady_sender;
	int cycle_count;
	int mismatch_count;
	int words_checked;
	int done_words;
	int refills_sent;
	int strays_sent;
	int cfg_writes;

	kway_merge_occurrence_records dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.run_index    (run_index),
		.has_record   (has_record),
		.rec_hash     (rec_hash),
		.page_id      (page_id),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_hash     (out_hash),
		.out_page     (out_page),
		.out_position (out_position),
		.source_run   (source_run),
		.all_done     (all_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.runs_in_use  (cfg_runs)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Number of runs taking part for the current register value.
	function automatic int runs_active();
		int n;
		n = int'(cfg_mirror);
		if (n < 1) n = 1;
		if (n > RUN_LIMIT) n = RUN_LIMIT;
		return n;
	endfunction

	// A register write restarts the merge: all heads drop, every run in use awaits a refill.
	function automatic void merge_restart(input logic [CFG_W-1:0] value);
		int n;
		int i;
		cfg_mirror = value;
		n = runs_active();
		for (i = 0; i < MAX_RUNS; i++) begin
			head_valid[i] = 1'b0;
			awaiting[i] = (i < n);
		end
	endfunction

	// True once no run awaits a refill and no head is left, so only done words follow.
	function automatic bit merge_finished();
		int i;
		for (i = 0; i < runs_active(); i++) begin
			if (awaiting[i] || head_valid[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Apply one accepted refill and queue the word it causes, if any.
	task automatic predict_refill(input logic [IDX_IN_W-1:0] idx, input logic has,
			input head_t key);
		int n;
		int i;
		int best;
		merge_word_t w;
		n = runs_active();
		if (idx < n && awaiting[idx]) begin
			awaiting[idx] = 1'b0;
			head_valid[idx] = has;
			if (has) heads[idx] = key;
		end
		for (i = 0; i < n; i++) begin
			if (awaiting[i]) return;
		end
		// The packed head compares as hash, then page, then position; ties keep the lower run.
		best = -1;
		for (i = 0; i < n; i++) begin
			if (head_valid[i] && (best < 0 || heads[i] < heads[best])) best = i;
		end
		w = '0;
		if (best < 0) begin
			w.done = 1'b1;
			done_words++;
		end else begin
			w.hash = heads[best].hash;
			w.page = heads[best].page;
			w.pos = heads[best].pos;
			w.src = IDX_IN_W'(best);
			head_valid[best] = 1'b0;
			awaiting[best] = 1'b1;
		end
		pending_words.push_back(w);
	endtask

	// Sender gap: mostly none, some short, a few long; none at all in steady phases.
	function automatic int pick_gap();
		int r;
		if (steady_sender) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Narrow keys collide often and exercise the tie rules; wide keys cover every bit.
	function automatic head_t random_key();
		head_t k;
		if (narrow_keys) begin
			k.hash = ($urandom_range(0, 7) == 0) ? '1 : 64'($urandom_range(0, 3));
			k.page = ($urandom_range(0, 7) == 0) ? '1 : 32'($urandom_range(0, 3));
			k.pos = ($urandom_range(0, 7) == 0) ? '1 : 32'($urandom_range(0, 3));
		end else begin
			k = {$urandom(), $urandom(), $urandom(), $urandom()};
		end
		return k;
	endfunction

	// Send one refill word after a random gap and predict its effect once accepted.
	task automatic send_refill(input logic [IDX_IN_W-1:0] idx, input logic has, input head_t key);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		run_index = idx;
		has_record = has;
		rec_hash = key.hash;
		page_id = key.page;
		position = key.pos;
		do @(posedge clk); while (in_stall);
		predict_refill(idx, has, key);
	endtask

	// Hold the sender off until every expected word has come out.
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Write the run count while the block is idle.
	task automatic configure(input logic [CFG_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_runs = value;
		do @(posedge clk); while (!cfg_ready);
		merge_restart(value);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sort order on every key field, ties, exhausted runs and a refill for a run not asked for.
	task automatic test_directed_order();
		int i;
		narrow_keys = 1'b0;
		steady_sender = 1'b0;
		send_refill(4'd0, 1'b1, '{'1, '1, '1});
		send_refill(4'd1, 1'b1, '{64'd0, '1, 32'd0});
		send_refill(4'd2, 1'b1, '{64'd0, 32'd0, '1});
		send_refill(4'd3, 1'b1, '{64'd0, 32'd0, 32'd0});
		send_refill(4'd4, 1'b1, '{64'd0, 32'd0, 32'd0});
		// Exhausted runs carry junk in the record fields, which must be ignored.
		for (i = 5; i < 15; i++) begin
			send_refill(IDX_IN_W'(i), 1'b0, '{'1, '1, '1});
		end
		send_refill(4'd15, 1'b1, '{64'h8000_0000_0000_0000, 32'd1, 32'd1});
		// Run 0 is not awaiting a refill, so this word changes nothing.
		send_refill(4'd0, 1'b1, '{64'd0, 32'd0, 32'd0});
		send_refill(4'd3, 1'b1, '{64'd0, 32'd0, 32'd0});
		send_refill(4'd3, 1'b0, '{64'd0, 32'd0, 32'd0});
		send_refill(4'd4, 1'b0, '{64'd0, 32'd0, 32'd0});
	endtask

	// Register extremes: zero acts as one, values above the run limit saturate.
	task automatic test_runs_in_use_bounds();
		configure(5'd0);
		send_refill(4'd0, 1'b1, random_key());
		send_refill(4'd0, 1'b0, random_key());
		send_refill(4'd9, 1'b1, random_key());
		configure(5'd31);
		send_refill(4'd15, 1'b1, '{'1, '1, '1});
		configure(5'd17);
		send_refill(4'd15, 1'b1, '{64'd0, 32'd0, 32'd0});
		configure(5'd1);
		send_refill(4'd0, 1'b0, '{'1, '1, '1});
		send_refill(4'd0, 1'b1, '{'1, '1, '1});
		configure(RUNS_AT_RESET);
	endtask

	// Complete merges with random run lengths and keys, mixed with stray words and restarts.
	task automatic test_random_merges();
		int value_pick;
		int n;
		int i;
		int step;
		int abandon_at;
		int phase;
		int cands [$];
		logic [IDX_IN_W-1:0] idx;
		logic has;
		head_t key;
		phase = 0;
		while (refills_sent < REFILL_TARGET) begin
			value_pick = $urandom_range(0, 99);
			if (value_pick < 15) configure(5'd1);
			else if (value_pick < 30) configure(5'd16);
			else if (value_pick < 35) configure(5'd0);
			else if (value_pick < 42) configure(CFG_W'($urandom_range(17, 31)));
			else configure(CFG_W'($urandom_range(2, 15)));
			n = runs_active();
			narrow_keys = ($urandom_range(0, 2) == 0);
			steady_sender = ($urandom_range(0, 4) == 0);
			for (i = 0; i < MAX_RUNS; i++) begin
				records_left[i] = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 6)
					: $urandom_range(7, 24);
			end
			// Some phases are cut short by the next register write.
			abandon_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * n + 4) : -1;
			step = 0;
			while (!merge_finished() && step != abandon_at) begin
				if ((phase == 0 && step == 3) || $urandom_range(0, 199) == 0) wait_drained();
				cands.delete();
				for (i = 0; i < n; i++) begin
					if (awaiting[i]) cands.push_back(i);
				end
				if ($urandom_range(0, 99) < 8 || cands.size() == 0)
					idx = IDX_IN_W'($urandom_range(0, MAX_RUNS - 1));
				else
					idx = IDX_IN_W'(cands[$urandom_range(0, cands.size() - 1)]);
				if (idx < n && awaiting[idx]) begin
					has = (records_left[idx] > 0) && ($urandom_range(0, 49) != 0);
					records_left[idx] = has ? records_left[idx] - 1 : 0;
					refills_sent++;
				end else begin
					has = 1'($urandom_range(0, 1));
					strays_sent++;
				end
				key = random_key();
				send_refill(idx, has, key);
				step++;
			end
			// Once the merge is over every word gives another done word.
			if (merge_finished()) begin
				repeat ($urandom_range(1, 2)) begin
					send_refill(IDX_IN_W'($urandom_range(0, MAX_RUNS - 1)),
						1'($urandom_range(0, 1)), random_key());
					strays_sent++;
				end
			end
			phase++;
		end
	endtask

	// Output stalls: free stretches alternate with short and occasional long stalls.
	initial begin
		int len;
		int r;
		out_stall = 1'b0;
		forever begin
			len = ($urandom_range(0, 99) < 15) ? $urandom_range(20, 60) : $urandom_range(0, 4);
			repeat (len) begin
				@(negedge clk);
				out_stall = 1'b0;
			end
			r = $urandom_range(0, 99);
			len = (r < 80) ? $urandom_range(1, 3) : (r < 95) ? $urandom_range(4, 10)
				: $urandom_range(20, 50);
			repeat (len) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
		end
	end

	// Compare each accepted output word with the oldest expected one.
	always @(posedge clk) begin : check_output
		merge_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected word: hash %h page %h pos %h run %0d done %b",
						out_hash, out_page, out_position, source_run, all_done);
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (out_hash !== want.hash || out_page !== want.page ||
						out_position !== want.pos || source_run !== want.src ||
						all_done !== want.done) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"Mismatch: expected hash %h page %h pos %h run %0d done %b,",
							" got hash %h page %h pos %h run %0d done %b"},
							want.hash, want.page, want.pos, want.src, want.done,
							out_hash, out_page, out_position, source_run, all_done);
				end
			end
		end
	end

	// A run that hangs ends here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d words outstanding",
			cycle_count, pending_words.size());
		$display("kway_merge_occurrence_records_test NOT OK");
		$finish;
	end

	// Reset, then the tests in turn, then drain and report.
	initial begin
		cycle_count = 0;
		mismatch_count = 0;
		words_checked = 0;
		done_words = 0;
		refills_sent = 0;
		strays_sent = 0;
		cfg_writes = 0;
		narrow_keys = 1'b0;
		steady_sender = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		run_index = '0;
		has_record = 1'b0;
		rec_hash = '0;
		page_id = '0;
		position = '0;
		cfg_valid = 1'b0;
		cfg_runs = RUNS_AT_RESET;
		merge_restart(RUNS_AT_RESET);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_order();
		test_runs_in_use_bounds();
		test_random_merges();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d refills and %0d stray words over %0d register writes.",
			refills_sent, strays_sent, cfg_writes);
		$display("Checked %0d output words, %0d of them done words; %0d mismatches.",
			words_checked, done_words, mismatch_count);
		if (mismatch_count == 0)
			$display("kway_merge_occurrence_records_test OK");
		else
			$display("kway_merge_occurrence_records_test NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/kmor_pkg.sv
hw/rtl/kmor_head_ram.sv
hw/rtl/kmor_min_unit.sv
hw/rtl/kway_merge_occurrence_records.sv
bench/kway_merge_occurrence_records_test.sv
